>>> hdl/ps2mt_pkg.sv
// Shared constants, types and codes of the PS/2 mouse packet tracker.
`timescale 1ns / 1ps
package ps2mt_pkg;

   localparam int COORD_BITS = 13;
   localparam int CFG_BITS   = 13;
   localparam int POS_BITS   = 13;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;
   localparam int CALC_W     = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
   localparam int COORD_MAX  = (2 ** COORD_BITS) - 1;

   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   localparam int FLAG_SYNC_BIT   = 3;
   localparam int FLAG_XSIGN_BIT  = 4;
   localparam int FLAG_YSIGN_BIT  = 5;
   localparam int FLAG_XOVF_BIT   = 6;
   localparam int FLAG_YOVF_BIT   = 7;
   localparam int FLAG_LEFT_BIT   = 0;
   localparam int FLAG_RIGHT_BIT  = 1;
   localparam int FLAG_MIDDLE_BIT = 2;

   typedef enum logic [1:0] {
      PH_FLAGS = 2'd0,
      PH_XMOVE = 2'd1,
      PH_YMOVE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] width;
      logic [CFG_BITS-1:0] height;
      logic                width_wr;
      logic                height_wr;
   } csr_type;

   typedef struct packed {
      logic       fire;
      logic [7:0] flags;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } pkt_type;

   typedef struct packed {
      logic [POS_BITS-1:0] pos_x;
      logic [POS_BITS-1:0] pos_y;
      logic                button_left;
      logic                button_right;
      logic                button_middle;
   } pos_type;

endpackage

>>> hdl/ps2mt_req_if.sv
// Byte input channel: received controller byte and its source flag.
`timescale 1ns / 1ps
interface ps2mt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       from_mouse;

   modport source (output valid, rx_byte, from_mouse, input ready);
   modport sink   (input valid, rx_byte, from_mouse, output ready);
endinterface

>>> hdl/ps2mt_rsp_if.sv
// Result channel: pointer position and button state per good packet.
`timescale 1ns / 1ps
interface ps2mt_rsp_if;
   import ps2mt_pkg::*;
   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] pos_x;
   logic [POS_BITS-1:0] pos_y;
   logic                button_left;
   logic                button_right;
   logic                button_middle;

   modport source (output valid, pos_x, pos_y, button_left, button_right, button_middle,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, button_left, button_right, button_middle,
                   output ready);
endinterface

>>> hdl/ps2mt_csr.sv
// APB register block holding the screen width and height.
`timescale 1ns / 1ps
module ps2mt_csr
   import ps2mt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output csr_type              csr
);

   logic [CFG_BITS-1:0] width_ff, width_in;
   logic [CFG_BITS-1:0] height_ff, height_in;
   logic                wr_en;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      csr.width_wr  = 1'b0;
      csr.height_wr = 1'b0;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SCREEN_WIDTH: begin
               width_in     = csr_pwdata[CFG_BITS-1:0];
               csr.width_wr = 1'b1;
            end
            REG_SCREEN_HEIGHT: begin
               height_in     = csr_pwdata[CFG_BITS-1:0];
               csr.height_wr = 1'b1;
            end
            default: ;
         endcase
      end
      csr.width  = width_in;
      csr.height = height_in;
   end

   always_comb begin
      unique case (reg_sel)
         REG_SCREEN_WIDTH:  csr_prdata = DATA_BITS'(width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = DATA_BITS'(height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

endmodule

>>> hdl/ps2mt_packet.sv
// Packet assembler: tracks the byte phase and collects flags and movement bytes.
`timescale 1ns / 1ps
module ps2mt_packet
   import ps2mt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  logic [7:0] rx_byte,
   input  logic       from_mouse,
   input  logic       step,
   output pkt_type    pkt
);

   phase_type  phase_ff, phase_in;
   logic [7:0] flag_ff, flag_in;
   logic [7:0] xbyte_ff, xbyte_in;
   logic       live;

   assign live = item_valid & from_mouse;

   always_comb begin
      phase_in = phase_ff;
      flag_in  = flag_ff;
      xbyte_in = xbyte_ff;
      if (live && step) begin
         unique case (phase_ff)
            PH_XMOVE: begin
               xbyte_in = rx_byte;
               phase_in = PH_YMOVE;
            end
            PH_YMOVE: phase_in = PH_FLAGS;
            default: begin
               if (rx_byte[FLAG_SYNC_BIT]) begin
                  flag_in  = rx_byte;
                  phase_in = PH_XMOVE;
               end else begin
                  phase_in = PH_FLAGS;
               end
            end
         endcase
      end
   end

   always_comb begin
      pkt.flags  = flag_ff;
      pkt.x_byte = xbyte_ff;
      pkt.y_byte = rx_byte;
      unique case (phase_ff)
         PH_YMOVE: pkt.fire = live & ~flag_ff[FLAG_XOVF_BIT] & ~flag_ff[FLAG_YOVF_BIT];
         default:  pkt.fire = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAGS;
         flag_ff  <= '0;
         xbyte_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         xbyte_ff <= xbyte_in;
      end
   end

endmodule

>>> hdl/ps2mt_cursor.sv
// Cursor update: applies movement, clamps to the screen, recenters on size writes.
`timescale 1ns / 1ps
module ps2mt_cursor
   import ps2mt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  pkt_type pkt,
   input  logic    step,
   output pos_type pos
);

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [8:0]        dx, dy;
   logic signed [CALC_W-1:0] sum_x, sum_y;
   logic [COORD_BITS-1:0]    new_x, new_y;

   function automatic logic signed [CALC_W-1:0] upper_limit(input logic [CFG_BITS-1:0] size);
      logic signed [CALC_W-1:0] lim;
      logic signed [CALC_W-1:0] sz;
      lim = CALC_W'(COORD_MAX);
      sz  = $signed(CALC_W'(size)) - CALC_W'(1);
      if (size != '0 && sz < lim) begin
         lim = sz;
      end
      return lim;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [CALC_W-1:0] v,
                                                   input logic [CFG_BITS-1:0] size);
      logic signed [CALC_W-1:0] lim;
      logic signed [CALC_W-1:0] r;
      lim = upper_limit(size);
      r   = v;
      if (r < 0) begin
         r = '0;
      end
      if (r > lim) begin
         r = lim;
      end
      return COORD_BITS'(r);
   endfunction

   function automatic logic [COORD_BITS-1:0] recenter(input logic [CFG_BITS-1:0] size);
      logic signed [CALC_W-1:0] c;
      c = $signed(CALC_W'(size >> 1));
      if (c > CALC_W'(COORD_MAX)) begin
         c = CALC_W'(COORD_MAX);
      end
      return COORD_BITS'(c);
   endfunction

   assign dx    = $signed({pkt.flags[FLAG_XSIGN_BIT], pkt.x_byte});
   assign dy    = $signed({pkt.flags[FLAG_YSIGN_BIT], pkt.y_byte});
   assign sum_x = $signed(CALC_W'(cur_x_ff)) + CALC_W'(dx);
   assign sum_y = $signed(CALC_W'(cur_y_ff)) - CALC_W'(dy);
   assign new_x = clamp(sum_x, csr.width);
   assign new_y = clamp(sum_y, csr.height);

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (step && pkt.fire) begin
         cur_x_in = new_x;
         cur_y_in = new_y;
      end
      if (csr.width_wr) begin
         cur_x_in = recenter(csr.width);
      end
      if (csr.height_wr) begin
         cur_y_in = recenter(csr.height);
      end
   end

   assign pos.pos_x         = POS_BITS'(new_x);
   assign pos.pos_y         = POS_BITS'(new_y);
   assign pos.button_left   = pkt.flags[FLAG_LEFT_BIT];
   assign pos.button_right  = pkt.flags[FLAG_RIGHT_BIT];
   assign pos.button_middle = pkt.flags[FLAG_MIDDLE_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

endmodule

>>> hdl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker.
//
// req_ch carries one controller byte per transfer with its from_mouse flag;
// bytes with from_mouse low are dropped without effect. Every third mouse
// byte of an aligned packet (flags byte with bit 3 set) yields one transfer
// on rsp_ch with the clamped pointer position and the three buttons, unless
// an overflow bit is set in the flags byte.
// A byte is taken into an input register and decoded from it; if it
// completes a good packet, the result lands in the output register and is
// presented on rsp_ch from there. One byte per cycle is sustained while
// rsp_ch accepts results; the single cursor update loop sets that rate.
// csr_* is an APB port: screen_width at 0x0, screen_height at 0x4; a write
// recenters that coordinate. Write only while the block is idle.
// Synchronous reset clears the byte phase, cursor and sizes and empties both
// registers. While rsp_ch stalls, bytes that complete no packet keep flowing;
// a byte that completes a packet waits in the input register.
`timescale 1ns / 1ps
module ps2_mouse_packet_tracker
   import ps2mt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ps2mt_req_if.sink            req_ch,
   ps2mt_rsp_if.source          rsp_ch,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   csr_type    csr;
   pkt_type    pkt;
   pos_type    pos;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_mouse_ff;
   logic       out_valid_ff, out_valid_in;
   pos_type    out_ff;
   logic       out_free;
   logic       step;
   logic       load;
   logic       take;

   ps2mt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr         (csr)
   );

   ps2mt_packet u_packet (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .rx_byte    (in_byte_ff),
      .from_mouse (in_mouse_ff),
      .step       (step),
      .pkt        (pkt)
   );

   ps2mt_cursor u_cursor (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .pkt   (pkt),
      .step  (step),
      .pos   (pos)
   );

   assign out_free     = ~out_valid_ff | rsp_ch.ready;
   assign step         = in_valid_ff & (~pkt.fire | out_free);
   assign load         = step & pkt.fire;
   assign req_ch.ready = ~in_valid_ff | step;
   assign take         = req_ch.valid & req_ch.ready;

   assign in_valid_in  = take | (in_valid_ff & ~step);
   assign out_valid_in = load | (out_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff  <= req_ch.rx_byte;
         in_mouse_ff <= req_ch.from_mouse;
      end
      if (load) begin
         out_ff <= pos;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.pos_x         = out_ff.pos_x;
   assign rsp_ch.pos_y         = out_ff.pos_y;
   assign rsp_ch.button_left   = out_ff.button_left;
   assign rsp_ch.button_right  = out_ff.button_right;
   assign rsp_ch.button_middle = out_ff.button_middle;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the PS/2 mouse packet tracker: directed packets, then random traffic.
`timescale 1ns / 1ps
module tb_top;
   import ps2mt_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BYTES = 160;

   typedef struct {
      logic [7:0] rx_byte;
      logic       from_mouse;
      logic       typed;
      pos_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ps2mt_req_if req_ch ();
   ps2mt_rsp_if rsp_ch ();

   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   logic calm     = 1'b0;
   logic hold_go  = 1'b0;
   logic hold_rsp = 1'b0;

   int mismatches  = 0;
   int rx_count    = 0;
   int idle_cycles = 0;

   pos_type pending_pos [$];

   phase_type           phase_q;
   logic [7:0]          flags_q;
   logic [7:0]          xbyte_q;
   int                  cur_x;
   int                  cur_y;
   logic [CFG_BITS-1:0] width_q;
   logic [CFG_BITS-1:0] height_q;

   stim_row_type script [24] = '{
      '{8'h08, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h08, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{13'd255, 13'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h0F, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, '{13'd255, 13'd0, 1'b1, 1'b1, 1'b1}},
      '{8'h38, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{13'd0, 13'd256, 1'b0, 1'b0, 1'b0}},
      '{8'h48, 1'b1, 1'b0, '0},
      '{8'h10, 1'b1, 1'b0, '0},
      '{8'h10, 1'b1, 1'b0, '0},
      '{8'h88, 1'b1, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b0, '0},
      '{8'h09, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'h18, 1'b1, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0}
   };

   ps2_mouse_packet_tracker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic int clamp_to(input int v, input logic [CFG_BITS-1:0] size);
      int top;
      top = COORD_MAX;
      if (size != 0 && int'(size) - 1 < top) top = int'(size) - 1;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   function automatic void track_byte(input logic [7:0] b, input logic mouse,
                                      output logic fired, output pos_type pos);
      int dx;
      int dy;
      fired = 1'b0;
      pos = '0;
      if (!mouse) return;
      case (phase_q)
         PH_XMOVE: begin
            xbyte_q = b;
            phase_q = PH_YMOVE;
         end
         PH_YMOVE: begin
            phase_q = PH_FLAGS;
            if (flags_q[FLAG_XOVF_BIT] || flags_q[FLAG_YOVF_BIT]) return;
            dx = int'(xbyte_q) - (flags_q[FLAG_XSIGN_BIT] ? 256 : 0);
            dy = int'(b) - (flags_q[FLAG_YSIGN_BIT] ? 256 : 0);
            cur_x = clamp_to(cur_x + dx, width_q);
            cur_y = clamp_to(cur_y - dy, height_q);
            fired = 1'b1;
            pos.pos_x = POS_BITS'(cur_x);
            pos.pos_y = POS_BITS'(cur_y);
            pos.button_left   = flags_q[FLAG_LEFT_BIT];
            pos.button_right  = flags_q[FLAG_RIGHT_BIT];
            pos.button_middle = flags_q[FLAG_MIDDLE_BIT];
         end
         default: begin
            if (b[FLAG_SYNC_BIT]) begin
               flags_q = b;
               phase_q = PH_XMOVE;
            end else begin
               phase_q = PH_FLAGS;
            end
         end
      endcase
   endfunction

   function automatic void log_mismatch(input string what, input pos_type want,
                                        input pos_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected x=%0d y=%0d l=%0b r=%0b m=%0b,",
                  $time, what, want.pos_x, want.pos_y, want.button_left, want.button_right,
                  want.button_middle, " got x=%0d y=%0d l=%0b r=%0b m=%0b",
                  got.pos_x, got.pos_y, got.button_left, got.button_right,
                  got.button_middle);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic m);
      if (!calm && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.rx_byte    <= b;
      req_ch.from_mouse <= m;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (m) rx_count++;
   endtask

   task automatic offer(input logic [7:0] b, input logic m, input logic typed,
                        input pos_type want);
      logic    fired;
      pos_type pos;
      send_byte(b, m);
      track_byte(b, m, fired, pos);
      if (fired) pending_pos.push_back(typed ? want : pos);
   endtask

   task automatic mouse_byte(input logic [7:0] b);
      if ($urandom_range(9) == 0) offer(8'($urandom), 1'b0, 1'b0, '0);
      offer(b, 1'b1, 1'b0, '0);
   endtask

   task automatic drain(input int tail);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input logic which, input logic [CFG_BITS-1:0] val);
      logic [DATA_BITS-1:0] word;
      word = $urandom();
      word[CFG_BITS-1:0] = val;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (which == REG_SCREEN_WIDTH) begin
         width_q = val;
         cur_x   = int'(val >> 1);
      end else begin
         height_q = val;
         cur_y    = int'(val >> 1);
      end
   endtask

   task automatic run_phase(input int budget, input bit with_hold, input bit with_pause);
      int         first;
      int         pk;
      int         dir;
      logic [7:0] flags;
      first = rx_count;
      pk    = 0;
      dir   = int'($urandom_range(2)) - 1;
      while (rx_count - first < budget) begin
         pk++;
         if (pk % 30 == 0) dir = (dir == 0) ? 1 : -dir;
         if (with_hold && pk == 20) hold_go <= 1'b1;
         if (with_pause && pk == 25) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_pos.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 2)) mouse_byte(8'($urandom));
         end else begin
            flags = 8'($urandom);
            flags[FLAG_SYNC_BIT] = 1'b1;
            if ($urandom_range(9) != 0) begin
               flags[FLAG_XOVF_BIT] = 1'b0;
               flags[FLAG_YOVF_BIT] = 1'b0;
            end
            if (dir != 0 && $urandom_range(9) < 6) begin
               flags[FLAG_XSIGN_BIT] = (dir < 0);
               flags[FLAG_YSIGN_BIT] = (dir > 0);
            end
            mouse_byte(flags);
            mouse_byte(8'($urandom));
            mouse_byte(8'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      pos_type got;
      pos_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.button_left, rsp_ch.button_right,
                 rsp_ch.button_middle};
         if (pending_pos.size() == 0) begin
            log_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_pos.pop_front();
            if (got !== want) log_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) rsp_ch.ready <= !hold_rsp && (calm || $urandom_range(99) >= 13);

   initial begin
      wait (hold_go);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [CFG_BITS-1:0] widths  [6];
      logic [CFG_BITS-1:0] heights [6];
      req_ch.valid      = 1'b0;
      req_ch.rx_byte    = '0;
      req_ch.from_mouse = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      phase_q  = PH_FLAGS;
      flags_q  = '0;
      xbyte_q  = '0;
      cur_x    = 0;
      cur_y    = 0;
      width_q  = '0;
      height_q = '0;
      widths  = '{13'd640, 13'd1, 13'd8191, 13'd0, 13'd2, CFG_BITS'($urandom_range(8191))};
      heights = '{13'd480, 13'd8191, 13'd1, 13'd0, 13'd3, CFG_BITS'($urandom_range(8191))};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i])
         offer(script[i].rx_byte, script[i].from_mouse, script[i].typed, script[i].want);
      drain(4);

      for (int p = 0; p < 6; p++) begin
         write_csr(REG_SCREEN_WIDTH, widths[p]);
         write_csr(REG_SCREEN_HEIGHT, heights[p]);
         calm <= (p == 2);
         run_phase(PHASE_BYTES, p == 1, p == 3);
         drain(4);
      end

      drain(8);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
